### design/rtn_pkg.sv
// ----------------------------------------------------------------------------
// rtn_pkg
// Shared constants for the ray/triangle nearest-hit core.
// ----------------------------------------------------------------------------
package rtn_pkg;

   localparam int COORD_WIDTH_DEF    = 32;
   localparam int FRACTION_BITS_DEF  = 16;
   localparam int ITEM_QUEUE_DEPTH   = 2;
   localparam int RESULT_QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_WIDTH = 3;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Z    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIRECTION_X = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIRECTION_Y = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIRECTION_Z = 3'd5;

endpackage

### design/rtn_fifo.sv
// ----------------------------------------------------------------------------
// rtn_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module rtn_fifo
   import rtn_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### design/rtn_front.sv
// ----------------------------------------------------------------------------
// rtn_front
// Takes a triangle and forms the edge vectors and the origin offset.
// ----------------------------------------------------------------------------
module rtn_front
   import rtn_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [COORD_WIDTH-1:0]      req_tri_a_x,
   input  logic signed [COORD_WIDTH-1:0]      req_tri_a_y,
   input  logic signed [COORD_WIDTH-1:0]      req_tri_a_z,
   input  logic signed [COORD_WIDTH-1:0]      req_tri_b_x,
   input  logic signed [COORD_WIDTH-1:0]      req_tri_b_y,
   input  logic signed [COORD_WIDTH-1:0]      req_tri_b_z,
   input  logic signed [COORD_WIDTH-1:0]      req_tri_c_x,
   input  logic signed [COORD_WIDTH-1:0]      req_tri_c_y,
   input  logic signed [COORD_WIDTH-1:0]      req_tri_c_z,
   input  logic                               req_last_triangle,
   input  logic [2:0][COORD_WIDTH-1:0]        origin,
   output logic                               item_push,
   input  logic                               item_full,
   output logic [9*(COORD_WIDTH+1):0]         item_data
);

   localparam int EW = COORD_WIDTH + 1;

   logic signed [EW-1:0] e1 [3];
   logic signed [EW-1:0] e2 [3];
   logic signed [EW-1:0] ao [3];
   logic signed [COORD_WIDTH-1:0] va [3];
   logic signed [COORD_WIDTH-1:0] vb [3];
   logic signed [COORD_WIDTH-1:0] vc [3];

   assign va[0] = req_tri_a_x;
   assign va[1] = req_tri_a_y;
   assign va[2] = req_tri_a_z;
   assign vb[0] = req_tri_b_x;
   assign vb[1] = req_tri_b_y;
   assign vb[2] = req_tri_b_z;
   assign vc[0] = req_tri_c_x;
   assign vc[1] = req_tri_c_y;
   assign vc[2] = req_tri_c_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e1[k] = EW'(vb[k]) - EW'(va[k]);
         e2[k] = EW'(vc[k]) - EW'(va[k]);
         ao[k] = EW'($signed(origin[k])) - EW'(va[k]);
      end
   end

   assign item_push = req_push;
   assign req_full  = item_full;
   assign item_data = {req_last_triangle,
                       ao[2], ao[1], ao[0],
                       e2[2], e2[1], e2[0],
                       e1[2], e1[1], e1[0]};

endmodule

### design/rtn_back.sv
// ----------------------------------------------------------------------------
// rtn_back
// Sequencer with a shared shift-add multiplier and a restoring divider that
// runs the intersection test and keeps the nearest hit.
// ----------------------------------------------------------------------------
module rtn_back
   import rtn_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [2:0][COORD_WIDTH-1:0]        origin,
   input  logic [2:0][COORD_WIDTH-1:0]        direction,
   input  logic                               item_empty,
   output logic                               item_pop,
   input  logic [9*(COORD_WIDTH+1):0]         item_data,
   input  logic                               res_full,
   output logic                               res_push,
   output logic [4*COORD_WIDTH:0]             res_data
);

   localparam int W   = COORD_WIDTH;
   localparam int EW  = W + 1;
   localparam int AW  = 3 * W + 8;
   localparam int DVW = AW + W;
   localparam int CW  = $clog2(W + 1);
   localparam int SB  = 5;
   localparam logic [SB-1:0] STEP_TN_LAST = 5'd23;
   localparam logic [SB-1:0] STEP_P_FIRST = 5'd24;
   localparam logic [SB-1:0] STEP_P_LAST  = 5'd26;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_MUL, ST_NORM, ST_TEST,
      ST_DIVCHK, ST_DIV, ST_PICK, ST_COMMIT, ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      S_NONE, S_E1, S_E2, S_AO, S_D, S_N, S_Q, S_T
   } src_type;

   typedef enum logic [3:0] {
      D_N0, D_N1, D_N2, D_DET, D_Q0, D_Q1, D_Q2,
      D_UN, D_VN, D_TN, D_P0, D_P1, D_P2
   } dst_type;

   typedef struct packed {
      src_type    xsel;
      logic [1:0] xi;
      src_type    ysel;
      logic [1:0] yi;
      logic       neg;
      logic       first;
      dst_type    dst;
   } mstep_type;

   function automatic mstep_type mk(src_type xs, logic [1:0] xi, src_type ys,
                                    logic [1:0] yi, logic neg, logic first,
                                    dst_type dst);
      mstep_type m;
      m.xsel  = xs;
      m.xi    = xi;
      m.ysel  = ys;
      m.yi    = yi;
      m.neg   = neg;
      m.first = first;
      m.dst   = dst;
      return m;
   endfunction

   // product schedule: cross products, determinant, numerators, hit point
   function automatic mstep_type step_of(logic [SB-1:0] p);
      mstep_type m;
      case (p)
         5'd0:    m = mk(S_E1, 2'd1, S_E2, 2'd2, 1'b0, 1'b1, D_N0);
         5'd1:    m = mk(S_E1, 2'd2, S_E2, 2'd1, 1'b1, 1'b0, D_N0);
         5'd2:    m = mk(S_E1, 2'd2, S_E2, 2'd0, 1'b0, 1'b1, D_N1);
         5'd3:    m = mk(S_E1, 2'd0, S_E2, 2'd2, 1'b1, 1'b0, D_N1);
         5'd4:    m = mk(S_E1, 2'd0, S_E2, 2'd1, 1'b0, 1'b1, D_N2);
         5'd5:    m = mk(S_E1, 2'd1, S_E2, 2'd0, 1'b1, 1'b0, D_N2);
         5'd6:    m = mk(S_N,  2'd0, S_D,  2'd0, 1'b1, 1'b1, D_DET);
         5'd7:    m = mk(S_N,  2'd1, S_D,  2'd1, 1'b1, 1'b0, D_DET);
         5'd8:    m = mk(S_N,  2'd2, S_D,  2'd2, 1'b1, 1'b0, D_DET);
         5'd9:    m = mk(S_AO, 2'd1, S_D,  2'd2, 1'b0, 1'b1, D_Q0);
         5'd10:   m = mk(S_AO, 2'd2, S_D,  2'd1, 1'b1, 1'b0, D_Q0);
         5'd11:   m = mk(S_AO, 2'd2, S_D,  2'd0, 1'b0, 1'b1, D_Q1);
         5'd12:   m = mk(S_AO, 2'd0, S_D,  2'd2, 1'b1, 1'b0, D_Q1);
         5'd13:   m = mk(S_AO, 2'd0, S_D,  2'd1, 1'b0, 1'b1, D_Q2);
         5'd14:   m = mk(S_AO, 2'd1, S_D,  2'd0, 1'b1, 1'b0, D_Q2);
         5'd15:   m = mk(S_Q,  2'd0, S_E2, 2'd0, 1'b0, 1'b1, D_UN);
         5'd16:   m = mk(S_Q,  2'd1, S_E2, 2'd1, 1'b0, 1'b0, D_UN);
         5'd17:   m = mk(S_Q,  2'd2, S_E2, 2'd2, 1'b0, 1'b0, D_UN);
         5'd18:   m = mk(S_Q,  2'd0, S_E1, 2'd0, 1'b1, 1'b1, D_VN);
         5'd19:   m = mk(S_Q,  2'd1, S_E1, 2'd1, 1'b1, 1'b0, D_VN);
         5'd20:   m = mk(S_Q,  2'd2, S_E1, 2'd2, 1'b1, 1'b0, D_VN);
         5'd21:   m = mk(S_N,  2'd0, S_AO, 2'd0, 1'b0, 1'b1, D_TN);
         5'd22:   m = mk(S_N,  2'd1, S_AO, 2'd1, 1'b0, 1'b0, D_TN);
         5'd23:   m = mk(S_N,  2'd2, S_AO, 2'd2, 1'b0, 1'b0, D_TN);
         5'd24:   m = mk(S_D,  2'd0, S_T,  2'd0, 1'b0, 1'b1, D_P0);
         5'd25:   m = mk(S_D,  2'd1, S_T,  2'd0, 1'b0, 1'b1, D_P1);
         5'd26:   m = mk(S_D,  2'd2, S_T,  2'd0, 1'b0, 1'b1, D_P2);
         default: m = mk(S_NONE, 2'd0, S_NONE, 2'd0, 1'b0, 1'b1, D_N0);
      endcase
      return m;
   endfunction

   state_type           state_ff;
   logic [SB-1:0]       step_ff;
   logic [CW-1:0]       bit_ff;
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [EW-1:0] ao_ff [3];
   logic                last_ff;
   logic signed [AW-1:0] n_ff [3];
   logic signed [AW-1:0] q_ff [3];
   logic signed [AW-1:0] praw_ff [3];
   logic signed [AW-1:0] det_ff, un_ff, vn_ff, tn_ff;
   logic signed [AW-1:0] acc_ff;
   logic [AW-1:0]       mcand_ff;
   logic [EW-1:0]       mplier_ff;
   logic                neg_ff;
   dst_type             dst_ff;
   logic [DVW-1:0]      rem_ff, dsh_ff;
   logic [W-1:0]        t_ff;
   logic [W-1:0]        nearest_t_ff;
   logic [W-1:0]        nearest_point_ff [3];
   logic                any_hit_ff;

   mstep_type           cur;
   logic signed [AW-1:0] xval;
   logic signed [EW-1:0] yval;
   logic [AW-1:0]       addend;
   logic signed [AW-1:0] acc_in;
   logic                last_bit;
   logic                hit_ok;
   logic [DVW-1:0]      num_in, det_top;
   logic                ge;
   logic signed [AW-1:0] sum_in [3];
   logic [W-1:0]        sat_in [3];

   assign cur = step_of(step_ff);

   always_comb begin
      case (cur.xsel)
         S_E1:    xval = AW'(e1_ff[cur.xi]);
         S_E2:    xval = AW'(e2_ff[cur.xi]);
         S_AO:    xval = AW'(ao_ff[cur.xi]);
         S_D:     xval = AW'($signed(direction[cur.xi]));
         S_N:     xval = n_ff[cur.xi];
         S_Q:     xval = q_ff[cur.xi];
         default: xval = '0;
      endcase
      case (cur.ysel)
         S_E1:    yval = e1_ff[cur.yi];
         S_E2:    yval = e2_ff[cur.yi];
         S_AO:    yval = ao_ff[cur.yi];
         S_D:     yval = EW'($signed(direction[cur.yi]));
         S_T:     yval = {1'b0, t_ff};
         default: yval = '0;
      endcase
   end

   // one multiplier bit per cycle, the sign bit weighs negative
   assign last_bit = (bit_ff == CW'(W));
   assign addend   = mplier_ff[0] ? mcand_ff : '0;
   assign acc_in   = (neg_ff ^ last_bit) ? acc_ff - $signed(addend)
                                         : acc_ff + $signed(addend);

   assign hit_ok = !un_ff[AW-1] && !vn_ff[AW-1] && !tn_ff[AW-1]
                   && !(det_ff < (un_ff + vn_ff));
   assign num_in  = DVW'($unsigned(tn_ff)) << FRACTION_BITS;
   assign det_top = DVW'($unsigned(det_ff)) << W;
   assign ge      = (rem_ff >= dsh_ff);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum_in[k] = AW'($signed(origin[k])) + (praw_ff[k] >>> FRACTION_BITS);
         if (sum_in[k][AW-1:W-1] == '0 || sum_in[k][AW-1:W-1] == '1) begin
            sat_in[k] = sum_in[k][W-1:0];
         end else begin
            sat_in[k] = sum_in[k][AW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end
      end
   end

   assign item_pop = (state_ff == ST_IDLE) && !item_empty;
   assign res_push = (state_ff == ST_FINISH) && last_ff && !res_full;
   assign res_data = {any_hit_ff,
                      any_hit_ff ? nearest_point_ff[0] : {W{1'b0}},
                      any_hit_ff ? nearest_point_ff[1] : {W{1'b0}},
                      any_hit_ff ? nearest_point_ff[2] : {W{1'b0}},
                      any_hit_ff ? nearest_t_ff : {W{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         bit_ff       <= '0;
         any_hit_ff   <= 1'b0;
         nearest_t_ff <= '1;
         for (int k = 0; k < 3; k++) begin
            nearest_point_ff[k] <= '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (!item_empty) begin
                  for (int k = 0; k < 3; k++) begin
                     e1_ff[k] <= item_data[k*EW +: EW];
                     e2_ff[k] <= item_data[(3+k)*EW +: EW];
                     ao_ff[k] <= item_data[(6+k)*EW +: EW];
                  end
                  last_ff  <= item_data[9*EW];
                  step_ff  <= '0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               mcand_ff  <= xval;
               mplier_ff <= yval;
               neg_ff    <= cur.neg;
               dst_ff    <= cur.dst;
               bit_ff    <= '0;
               if (cur.first) begin
                  acc_ff <= '0;
               end
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               acc_ff    <= acc_in;
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               bit_ff    <= bit_ff + 1'b1;
               if (last_bit) begin
                  case (dst_ff)
                     D_N0:    n_ff[0] <= acc_in;
                     D_N1:    n_ff[1] <= acc_in;
                     D_N2:    n_ff[2] <= acc_in;
                     D_DET:   det_ff <= acc_in;
                     D_Q0:    q_ff[0] <= acc_in;
                     D_Q1:    q_ff[1] <= acc_in;
                     D_Q2:    q_ff[2] <= acc_in;
                     D_UN:    un_ff <= acc_in;
                     D_VN:    vn_ff <= acc_in;
                     D_TN:    tn_ff <= acc_in;
                     D_P0:    praw_ff[0] <= acc_in;
                     D_P1:    praw_ff[1] <= acc_in;
                     D_P2:    praw_ff[2] <= acc_in;
                     default: ;
                  endcase
                  step_ff <= step_ff + 1'b1;
                  if (step_ff == STEP_TN_LAST) begin
                     state_ff <= ST_NORM;
                  end else if (step_ff == STEP_P_LAST) begin
                     state_ff <= ST_COMMIT;
                  end else begin
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_NORM: begin
               if (det_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  if (det_ff[AW-1]) begin
                     det_ff <= -det_ff;
                     un_ff  <= -un_ff;
                     vn_ff  <= -vn_ff;
                     tn_ff  <= -tn_ff;
                  end
                  state_ff <= ST_TEST;
               end
            end
            ST_TEST: begin
               rem_ff   <= num_in;
               state_ff <= hit_ok ? ST_DIVCHK : ST_FINISH;
            end
            ST_DIVCHK: begin
               // quotient would not fit: distance saturates
               if (rem_ff >= det_top) begin
                  t_ff     <= '1;
                  state_ff <= ST_PICK;
               end else begin
                  dsh_ff   <= det_top >> 1;
                  bit_ff   <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (ge) begin
                  rem_ff <= rem_ff - dsh_ff;
               end
               t_ff   <= {t_ff[W-2:0], ge};
               dsh_ff <= dsh_ff >> 1;
               bit_ff <= bit_ff + 1'b1;
               if (bit_ff == CW'(W - 1)) begin
                  state_ff <= ST_PICK;
               end
            end
            ST_PICK: begin
               // ties keep the earlier triangle
               if (!any_hit_ff || (t_ff < nearest_t_ff)) begin
                  step_ff  <= STEP_P_FIRST;
                  state_ff <= ST_LOAD;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_COMMIT: begin
               for (int k = 0; k < 3; k++) begin
                  nearest_point_ff[k] <= sat_in[k];
               end
               nearest_t_ff <= t_ff;
               any_hit_ff   <= 1'b1;
               state_ff     <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!last_ff) begin
                  state_ff <= ST_IDLE;
               end else if (!res_full) begin
                  any_hit_ff   <= 1'b0;
                  nearest_t_ff <= '1;
                  for (int k = 0; k < 3; k++) begin
                     nearest_point_ff[k] <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_clear_after_word: assert property (@(posedge clock) disable iff (reset)
      res_push |=> !any_hit_ff && state_ff == ST_IDLE)
      else $error("mesh state not cleared after result word");

   a_no_hit_max_t: assert property (@(posedge clock) disable iff (reset)
      !any_hit_ff |-> nearest_t_ff == '1)
      else $error("nearest distance set without a hit");

   a_no_hit_zero_point: assert property (@(posedge clock) disable iff (reset)
      !any_hit_ff |-> (nearest_point_ff[0] == '0 && nearest_point_ff[1] == '0
                       && nearest_point_ff[2] == '0))
      else $error("hit point set without a hit");

   a_commit_sets_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |=> any_hit_ff && nearest_t_ff == $past(t_ff))
      else $error("commit did not record the hit");

endmodule

### design/ray_triangle_nearest_hit_core.sv
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_core
// Streams triangles against one configured ray and reports the nearest hit.
// ----------------------------------------------------------------------------
// Triangles are pushed into a two-word queue; the back end takes one at a time
// and runs every product on a single shift-add multiplier, one multiplier bit
// per cycle, then a restoring divider one quotient bit per cycle. Every
// triangle runs the products up to the distance numerator and stops there
// when its determinant is zero or the ray misses it; one that the ray crosses
// also goes through the divider (skipped when the distance saturates), and one
// that becomes the new nearest hit runs the three hit-point products as well.
// The last triangle may also wait for room in the result queue. Most of the
// time goes to the multiplier. After the triangle marked last, one result word
// appears on the rsp_ side and the hit state starts over.
module ray_triangle_nearest_hit_core
   import rtn_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_data,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [COORD_WIDTH-1:0] req_tri_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_tri_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_tri_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_tri_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_tri_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_tri_b_z,
   input  logic signed [COORD_WIDTH-1:0] req_tri_c_x,
   input  logic signed [COORD_WIDTH-1:0] req_tri_c_y,
   input  logic signed [COORD_WIDTH-1:0] req_tri_c_z,
   input  logic                          req_last_triangle,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_hit_found,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_x,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_y,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_z,
   output logic [COORD_WIDTH-1:0]        rsp_hit_distance
);

   localparam int W  = COORD_WIDTH;
   localparam int IW = 9 * (W + 1) + 1;
   localparam int RW = 4 * W + 1;

   logic [2:0][W-1:0] origin_ff;
   logic [2:0][W-1:0] direction_ff;
   logic              item_push, item_full, item_pop, item_empty;
   logic [IW-1:0]     item_wdata, item_rdata;
   logic              res_push, res_full;
   logic [RW-1:0]     res_wdata, res_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff       <= '0;
         direction_ff[0] <= W'(1) << FRACTION_BITS;
         direction_ff[1] <= '0;
         direction_ff[2] <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X:    origin_ff[0]    <= csr_data;
            CSR_ORIGIN_Y:    origin_ff[1]    <= csr_data;
            CSR_ORIGIN_Z:    origin_ff[2]    <= csr_data;
            CSR_DIRECTION_X: direction_ff[0] <= csr_data;
            CSR_DIRECTION_Y: direction_ff[1] <= csr_data;
            CSR_DIRECTION_Z: direction_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   rtn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .req_push          (req_push),
      .req_full          (req_full),
      .req_tri_a_x       (req_tri_a_x),
      .req_tri_a_y       (req_tri_a_y),
      .req_tri_a_z       (req_tri_a_z),
      .req_tri_b_x       (req_tri_b_x),
      .req_tri_b_y       (req_tri_b_y),
      .req_tri_b_z       (req_tri_b_z),
      .req_tri_c_x       (req_tri_c_x),
      .req_tri_c_y       (req_tri_c_y),
      .req_tri_c_z       (req_tri_c_z),
      .req_last_triangle (req_last_triangle),
      .origin            (origin_ff),
      .item_push         (item_push),
      .item_full         (item_full),
      .item_data         (item_wdata)
   );

   rtn_fifo #(.WIDTH(IW), .DEPTH(ITEM_QUEUE_DEPTH)) u_item_q (
      .clock   (clock),
      .reset   (reset),
      .push    (item_push),
      .full    (item_full),
      .wr_data (item_wdata),
      .pop     (item_pop),
      .empty   (item_empty),
      .rd_data (item_rdata)
   );

   rtn_back #(.COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .origin     (origin_ff),
      .direction  (direction_ff),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .item_data  (item_rdata),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_data   (res_wdata)
   );

   rtn_fifo #(.WIDTH(RW), .DEPTH(RESULT_QUEUE_DEPTH)) u_res_q (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .full    (res_full),
      .wr_data (res_wdata),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (res_rdata)
   );

   assign rsp_hit_found    = res_rdata[4*W];
   assign rsp_hit_x        = res_rdata[3*W +: W];
   assign rsp_hit_y        = res_rdata[2*W +: W];
   assign rsp_hit_z        = res_rdata[W +: W];
   assign rsp_hit_distance = res_rdata[W-1:0];

endmodule
